FILE: hw/rtl/pzip_pkg.sv
// shared types, constants and helper functions of the postnet zip encoder
package pzip_pkg;

  localparam int unsigned ZipWidth   = 17;
  localparam int unsigned BarWidth   = 32;
  localparam int unsigned CheckWidth = 4;
  localparam int unsigned DigitWidth = 4;
  localparam int unsigned CodeWidth  = 5;
  localparam int unsigned NumDigits  = 5;
  localparam int unsigned SumWidth   = 6;

  localparam logic [ZipWidth-1:0] ZipMax = ZipWidth'(99999);

  // reciprocal of ten, exact floor for any 17-bit value
  localparam int unsigned Div10Shift = 21;
  localparam logic [17:0] Div10Mult  = 18'd209716;
  localparam int unsigned QuotWidth  = ZipWidth - 3;

  localparam int unsigned DefaultQueueDepth = 2;

  // two-of-five codes, first bar in bit 4
  localparam logic [CodeWidth-1:0] DigitCode [10] = '{
    5'b11000, 5'b00011, 5'b00101, 5'b00110, 5'b01001,
    5'b01010, 5'b01100, 5'b10001, 5'b10010, 5'b10100
  };

  // item handed from the front part to the back part
  typedef struct packed {
    logic [ZipWidth-1:0] zip;
    logic                oor;
  } item_t;

  typedef logic [NumDigits-1:0][DigitWidth-1:0] digits_t;

  // floor of v / 10 through the reciprocal
  function automatic logic [QuotWidth-1:0] div10(logic [ZipWidth-1:0] v);
    logic [ZipWidth+17:0] prod;
    prod = (ZipWidth+18)'(v) * (ZipWidth+18)'(Div10Mult);
    return prod[Div10Shift +: QuotWidth];
  endfunction

  // bar code of one digit, codes above nine wrap mod ten
  function automatic logic [CodeWidth-1:0] digit_code(logic [DigitWidth-1:0] d);
    logic [DigitWidth-1:0] idx;
    idx = (d >= DigitWidth'(10)) ? (d - DigitWidth'(10)) : d;
    return DigitCode[idx];
  endfunction

  // ten minus sum mod ten, with ten folded to zero
  function automatic logic [CheckWidth-1:0] check_of(logic [SumWidth-1:0] s);
    logic [SumWidth-1:0] r;
    r = s;
    if (r >= SumWidth'(40)) begin
      r = r - SumWidth'(40);
    end else if (r >= SumWidth'(30)) begin
      r = r - SumWidth'(30);
    end else if (r >= SumWidth'(20)) begin
      r = r - SumWidth'(20);
    end else if (r >= SumWidth'(10)) begin
      r = r - SumWidth'(10);
    end
    return (r == '0) ? '0 : CheckWidth'(SumWidth'(10) - r);
  endfunction

endpackage

FILE: hw/rtl/pzip_in_if.sv
// input channel carrying one zip code word
interface pzip_in_if;
  logic                          valid;
  logic                          ready;
  logic [pzip_pkg::ZipWidth-1:0] zip_code;

  modport source (output valid, output zip_code, input ready);
  modport sink   (input valid, input zip_code, output ready);
endinterface

FILE: hw/rtl/pzip_out_if.sv
// output channel carrying one bar pattern word
interface pzip_out_if;
  logic                            valid;
  logic                            ready;
  logic [pzip_pkg::BarWidth-1:0]   bar_pattern;
  logic [pzip_pkg::CheckWidth-1:0] check_digit;
  logic                            out_of_range;

  modport source (output valid, output bar_pattern, output check_digit,
                  output out_of_range, input ready);
  modport sink   (input valid, input bar_pattern, input check_digit,
                  input out_of_range, output ready);
endinterface

FILE: hw/rtl/postnet_zip_barcode_encoder_core.sv
// An accepted zip word passes through the front register, the queue, five digit
// split stages and the output register before its bar word is valid.
// Throughput: one word per cycle, set by the back pipeline that advances as a
// whole whenever the output is free.
// Reset clears only valid flags, queue pointers and fill count; no clearing pass.
module postnet_zip_barcode_encoder_core #(
  parameter int unsigned QueueDepth = pzip_pkg::DefaultQueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pzip_in_if.sink    zip_i,
  pzip_out_if.source bar_o
);

  logic            fr_valid, fr_ready;
  pzip_pkg::item_t fr_item;
  logic            bk_valid, bk_ready;
  pzip_pkg::item_t bk_item;

  // accept and classify
  pzip_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (zip_i),
    .item_valid_o (fr_valid),
    .item_ready_i (fr_ready),
    .item_o       (fr_item)
  );

  // decoupling queue
  pzip_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_item_i  (fr_item),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_item_o   (bk_item)
  );

  // digit split and bar assembly
  pzip_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (bk_valid),
    .item_ready_o (bk_ready),
    .item_i       (bk_item),
    .out_o        (bar_o)
  );

endmodule

FILE: hw/rtl/pzip_front.sv
// front part: accepts zip words and flags out of range values
module pzip_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  pzip_in_if.sink          in_i,
  output logic             item_valid_o,
  input  logic             item_ready_i,
  output pzip_pkg::item_t  item_o
);

  logic            valid_q, valid_d;
  pzip_pkg::item_t item_q, item_d;
  logic            load;

  // accept when the holding register is empty or drains this cycle
  assign in_i.ready = !valid_q || item_ready_i;
  assign load       = in_i.valid && in_i.ready;

  // classify the incoming word
  always_comb begin
    item_d     = item_q;
    valid_d    = valid_q;
    if (load) begin
      item_d.zip = in_i.zip_code;
      item_d.oor = (in_i.zip_code > pzip_pkg::ZipMax);
      valid_d    = 1'b1;
    end else if (item_ready_i) begin
      valid_d    = 1'b0;
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

FILE: hw/rtl/pzip_queue.sv
// short queue between the front and back parts
module pzip_queue #(
  parameter int unsigned Depth = pzip_pkg::DefaultQueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  pzip_pkg::item_t  push_item_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output pzip_pkg::item_t  pop_item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  pzip_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_item_o   = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

FILE: hw/rtl/pzip_back.sv
// back part: digit split pipeline, check digit and bar assembly
module pzip_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  output logic             item_ready_o,
  input  pzip_pkg::item_t  item_i,
  pzip_out_if.source       out_o
);

  localparam int unsigned N  = pzip_pkg::NumDigits;
  localparam int unsigned ZW = pzip_pkg::ZipWidth;
  localparam int unsigned DW = pzip_pkg::DigitWidth;

  logic                  en;
  logic                  st_valid_q [N];
  logic [ZW-1:0]         st_val_q  [N];
  logic                  st_oor_q  [N];
  pzip_pkg::digits_t     st_dig_q  [N];

  logic [ZW-1:0]         src_val   [N];
  logic                  src_oor   [N];
  logic                  src_valid [N];
  pzip_pkg::digits_t     src_dig   [N];

  logic                  out_valid_q;
  logic [pzip_pkg::BarWidth-1:0]   bar_q, bar_d;
  logic [pzip_pkg::CheckWidth-1:0] chk_q, chk_d;
  logic                  oor_q;

  // whole pipeline advances unless the output word is stalled
  assign en           = !out_valid_q || out_o.ready;
  assign item_ready_o = en;

  // stage inputs: queue head for the first, previous stage otherwise
  always_comb begin
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        src_val[k]   = item_i.zip;
        src_oor[k]   = item_i.oor;
        src_valid[k] = item_valid_i;
        src_dig[k]   = '0;
      end else begin
        src_val[k]   = st_val_q[k-1];
        src_oor[k]   = st_oor_q[k-1];
        src_valid[k] = st_valid_q[k-1];
        src_dig[k]   = st_dig_q[k-1];
      end
    end
  end

  // one digit per stage, least significant first
  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [pzip_pkg::QuotWidth-1:0] quot;
    logic [ZW-1:0]                  rem;
    pzip_pkg::digits_t              dig_d;

    always_comb begin
      quot  = pzip_pkg::div10(src_val[k]);
      rem   = src_val[k] - ((ZW'(quot) << 3) + (ZW'(quot) << 1));
      dig_d = src_dig[k];
      dig_d[N-1-k] = rem[DW-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_valid_q[k] <= 1'b0;
      end else if (en) begin
        st_valid_q[k] <= src_valid[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        st_val_q[k] <= ZW'(quot);
        st_oor_q[k] <= src_oor[k];
        st_dig_q[k] <= dig_d;
      end
    end
  end

  // check digit and bar frame from the full digit set
  always_comb begin
    logic [pzip_pkg::SumWidth-1:0]   sum;
    logic [pzip_pkg::CheckWidth-1:0] chk;
    logic [pzip_pkg::BarWidth-1:0]   pat;
    sum = '0;
    for (int i = 0; i < N; i++) begin
      sum = sum + pzip_pkg::SumWidth'(st_dig_q[N-1][i]);
    end
    chk = pzip_pkg::check_of(sum);
    pat = {1'b1,
           pzip_pkg::digit_code(st_dig_q[N-1][0]),
           pzip_pkg::digit_code(st_dig_q[N-1][1]),
           pzip_pkg::digit_code(st_dig_q[N-1][2]),
           pzip_pkg::digit_code(st_dig_q[N-1][3]),
           pzip_pkg::digit_code(st_dig_q[N-1][4]),
           pzip_pkg::digit_code(chk),
           1'b1};
    if (st_oor_q[N-1]) begin
      bar_d = '0;
      chk_d = '0;
    end else begin
      bar_d = pat;
      chk_d = chk;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= st_valid_q[N-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      bar_q <= bar_d;
      chk_q <= chk_d;
      oor_q <= st_oor_q[N-1];
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.bar_pattern  = bar_q;
  assign out_o.check_digit  = chk_q;
  assign out_o.out_of_range = oor_q;

endmodule

FILE: hw/rtl/pzip_checker.sv
// port level checks of the postnet zip encoder, bound to the top level
module pzip_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic [pzip_pkg::BarWidth-1:0]   bar_pattern_i,
  input logic [pzip_pkg::CheckWidth-1:0] check_digit_i,
  input logic                            out_of_range_i
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(bar_pattern_i)
      && $stable(check_digit_i) && $stable(out_of_range_i))
    else $error("result word changed while stalled");

  // flagged words carry no bars
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_of_range_i |-> bar_pattern_i == '0 && check_digit_i == '0)
    else $error("out of range word carries bars");

  // valid words are framed and have a decimal check digit
  a_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_of_range_i |-> bar_pattern_i[31] && bar_pattern_i[0]
      && check_digit_i <= 4'd9)
    else $error("bad frame bars or check digit");

  // six two-of-five codes plus two frame bars
  a_full_bars: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_of_range_i |-> $countones(bar_pattern_i) == 14)
    else $error("wrong number of full bars");

endmodule

bind postnet_zip_barcode_encoder_core pzip_checker u_pzip_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (bar_o.valid),
  .out_ready_i    (bar_o.ready),
  .bar_pattern_i  (bar_o.bar_pattern),
  .check_digit_i  (bar_o.check_digit),
  .out_of_range_i (bar_o.out_of_range)
);

FILE: verif/pzip_checker.sv
// watches both channels of the postnet zip encoder and checks every bar word
module pzip_scoreboard (
  input  logic        clk_i,
  input  logic        rst_ni,
  pzip_in_if          zip_i,
  pzip_out_if         bar_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned flagged_o,
  output int unsigned zero_check_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // one expected bar word
  typedef struct packed {
    logic [pzip_pkg::BarWidth-1:0]   bar;
    logic [pzip_pkg::CheckWidth-1:0] check;
    logic                            oor;
  } bar_word_t;

  // two-of-five codes per decimal digit, first bar in the msb
  localparam logic [4:0] TwoOfFive [10] = '{
    5'b11000, 5'b00011, 5'b00101, 5'b00110, 5'b01001,
    5'b01010, 5'b01100, 5'b10001, 5'b10010, 5'b10100
  };

  bar_word_t   expected_bars_q [$];
  int unsigned fails;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;
  int unsigned flagged;
  int unsigned zero_check;

  assign fail_count_o = fails;
  assign pending_o    = pending;
  assign checked_o    = checked;
  assign flagged_o    = flagged;
  assign zero_check_o = zero_check;

  // bar word that one zip code should give
  function automatic bar_word_t postnet_encode(logic [pzip_pkg::ZipWidth-1:0] zip);
    bar_word_t   w;
    int unsigned rest;
    int unsigned dig [5];
    int unsigned sum;
    int unsigned chk;
    w = '0;
    if (zip > 17'd99999) begin
      w.oor = 1'b1;
      return w;
    end
    rest = zip;
    sum  = 0;
    for (int i = 4; i >= 0; i--) begin
      dig[i] = rest % 10;
      sum   += dig[i];
      rest   = rest / 10;
    end
    chk = (10 - (sum % 10)) % 10;
    w.bar = {1'b1, TwoOfFive[dig[0]], TwoOfFive[dig[1]], TwoOfFive[dig[2]],
             TwoOfFive[dig[3]], TwoOfFive[dig[4]], TwoOfFive[chk], 1'b1};
    w.check = pzip_pkg::CheckWidth'(chk);
    return w;
  endfunction

  // predict on every accepted zip word, compare on every accepted bar word
  always @(posedge clk_i or negedge rst_ni) begin
    bar_word_t want;
    bar_word_t got;
    if (!rst_ni) begin
      expected_bars_q.delete();
      fails      = 0;
      mismatches = 0;
      pending    = 0;
      checked    = 0;
      flagged    = 0;
      zero_check = 0;
    end else begin
      if (zip_i.valid && zip_i.ready) begin
        expected_bars_q.push_back(postnet_encode(zip_i.zip_code));
      end
      if (bar_i.valid && bar_i.ready) begin
        got.bar   = bar_i.bar_pattern;
        got.check = bar_i.check_digit;
        got.oor   = bar_i.out_of_range;
        if (expected_bars_q.size() == 0) begin
          fails++;
          mismatches++;
          if (mismatches <= 10) begin
            $display("%t unexpected bar word: bar %h check %0d oor %b",
                     $realtime, got.bar, got.check, got.oor);
          end
        end else begin
          want = expected_bars_q.pop_front();
          checked++;
          if (want.oor) flagged++;
          else if (want.check == '0) zero_check++;
          if (got.bar !== want.bar || got.check !== want.check ||
              got.oor !== want.oor) begin
            fails++;
            mismatches++;
            if (mismatches <= 10) begin
              $display("%t bar word mismatch: expected bar %h check %0d oor %b,",
                       $realtime, want.bar, want.check, want.oor);
              $display("    got bar %h check %0d oor %b",
                       got.bar, got.check, got.oor);
            end
          end
        end
      end
      pending = expected_bars_q.size();
    end
  end

endmodule

FILE: verif/testbench.sv
// top of the postnet zip encoder testbench: clock, reset, stimulus and verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  bit          quiet;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned flagged;
  int unsigned zero_check;
  int unsigned sent;

  pzip_in_if  zip_if ();
  pzip_out_if bar_if ();

  postnet_zip_barcode_encoder_core u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .zip_i  (zip_if),
    .bar_o  (bar_if)
  );

  pzip_scoreboard u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .zip_i        (zip_if),
    .bar_i        (bar_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .flagged_o    (flagged),
    .zero_check_o (zero_check)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stalls about a third of the time, never in the quiet stretch
  always @(negedge clk) begin
    bar_if.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 34);
  end

  // hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // offer one zip word after a random gap, hold it until taken
  task automatic send_zip(input logic [pzip_pkg::ZipWidth-1:0] zip);
    while (!quiet && $urandom_range(99) < 34) begin
      zip_if.valid    <= 1'b0;
      zip_if.zip_code <= pzip_pkg::ZipWidth'($urandom);
      @(negedge clk);
    end
    zip_if.valid    <= 1'b1;
    zip_if.zip_code <= zip;
    do @(posedge clk); while (!zip_if.ready);
    sent++;
    @(negedge clk);
  endtask

  // random zip code, mostly valid with some flagged values and edges
  function automatic logic [pzip_pkg::ZipWidth-1:0] random_zip();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 80) return pzip_pkg::ZipWidth'($urandom_range(99999));
    if (pick < 92) return pzip_pkg::ZipWidth'($urandom_range(131071, 100000));
    case ($urandom_range(3))
      0:       return '0;
      1:       return pzip_pkg::ZipWidth'(99999);
      2:       return pzip_pkg::ZipWidth'(100000);
      default: return '1;
    endcase
  endfunction

  // directed corners: field extremes, check digit zero, range boundary
  localparam int unsigned NumDirected = 22;
  localparam logic [pzip_pkg::ZipWidth-1:0] DirectedZips [NumDirected] = '{
    17'd0, 17'd99999, 17'd100000, 17'd131071, 17'd99998, 17'd1,
    17'd19, 17'd28, 17'd55, 17'd12345, 17'd67890, 17'd98765,
    17'd43210, 17'd13579, 17'd24680, 17'd10000, 17'd50000, 17'd55555,
    17'd65536, 17'd90001, 17'd11116, 17'd99990
  };

  initial begin
    zip_if.valid    = 1'b0;
    zip_if.zip_code = '0;
    bar_if.ready    = 1'b0;
    quiet           = 1'b0;
    sent            = 0;
    rst_n           = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (DirectedZips[i]) send_zip(DirectedZips[i]);

    // random words, with a long stretch where neither side idles
    for (int n = 0; n < 1100; n++) begin
      quiet = (n >= 300 && n < 550);
      send_zip(random_zip());
    end
    quiet = 1'b0;
    zip_if.valid <= 1'b0;

    // drain, then give stray words time to show up
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    @(negedge clk);

    $display("sent %0d zip words, checked %0d bar words", sent, checked);
    $display("%0d flagged out of range, %0d with check digit zero", flagged, zero_check);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
